// ----- sv/ospc_pkg.sv -----
// Package for the occupancy power switch control block.
// Holds widths, command and register codes, and the shared structs.
// No dependencies.
package ospc_pkg;

  // Default width of the seconds clock and the time stamps
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // Widths of the configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned HOLD_W     = 16;

  // Register reset values
  localparam logic [HOLD_W-1:0] KEY_HOLD_RST  = HOLD_W'(60);
  localparam logic [HOLD_W-1:0] PRES_HOLD_RST = HOLD_W'(60);

  // Item command codes
  typedef enum logic [1:0] {
    CMD_KEY      = 2'd0,
    CMD_PRESENCE = 2'd1,
    CMD_REMOTE   = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_e;

  // Remote requests; code 3 means nothing and is ignored
  typedef enum logic [1:0] {
    REM_INVALID = 2'd0,
    REM_ON      = 2'd1,
    REM_OFF     = 2'd2
  } remote_e;

  // Key debounce phases
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_FILTER   = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_RELEASED = 2'd3
  } phase_e;

  // Configuration register indexes; index 3 is unused
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HOLD  = 2'd0,
    REG_PRES_HOLD = 2'd1,
    REG_REMOTE_EN = 2'd2
  } cfg_reg_e;

  // Configuration seen by the control logic
  typedef struct packed {
    logic [HOLD_W-1:0] key_hold;
    logic [HOLD_W-1:0] pres_hold;
    logic              remote_en;
  } ospc_cfg_t;

  // One input item
  typedef struct packed {
    logic [1:0] command;
    logic       key_level;
    logic       presence_level;
    logic [1:0] remote_cmd;
  } ospc_item_t;

  // One result item
  typedef struct packed {
    logic       power_drive;
    logic       switch_is_on;
    logic [1:0] key_phase_out;
    logic       presence_report;
    logic       off_accepted;
  } ospc_res_t;

endpackage

// ----- sv/ospc_in_if.sv -----
// Input item channel of the occupancy power switch control block.
// Valid/ready handshake with the item fields; no dependencies.
interface ospc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       key_level;
  logic       presence_level;
  logic [1:0] remote_cmd;

  modport source (output valid, command, key_level, presence_level, remote_cmd,
                  input ready);
  modport sink   (input valid, command, key_level, presence_level, remote_cmd,
                  output ready);
endinterface

// ----- sv/ospc_out_if.sv -----
// Result item channel of the occupancy power switch control block.
// Valid/ready handshake with the result fields; no dependencies.
interface ospc_out_if;
  logic       valid;
  logic       ready;
  logic       power_drive;
  logic       switch_is_on;
  logic [1:0] key_phase_out;
  logic       presence_report;
  logic       off_accepted;

  modport source (output valid, power_drive, switch_is_on, key_phase_out,
                  presence_report, off_accepted, input ready);
  modport sink   (input valid, power_drive, switch_is_on, key_phase_out,
                  presence_report, off_accepted, output ready);
endinterface

// ----- sv/ospc_cfg_regs.sv -----
// Configuration registers of the occupancy power switch control block.
// Decodes the plain write port; depends on ospc_pkg.
module ospc_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ospc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ospc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output ospc_pkg::ospc_cfg_t                cfg_o
);
  import ospc_pkg::*;

  ospc_cfg_t cfg_q, cfg_d;

  // Register write decode; unused index is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_HOLD:  cfg_d.key_hold  = cfg_wdata_i[HOLD_W-1:0];
        REG_PRES_HOLD: cfg_d.pres_hold = cfg_wdata_i[HOLD_W-1:0];
        REG_REMOTE_EN: cfg_d.remote_en = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_hold  <= KEY_HOLD_RST;
      cfg_q.pres_hold <= PRES_HOLD_RST;
      cfg_q.remote_en <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/ospc_ctrl.sv -----
// Switch control state and per-item update logic.
// Holds debounce phase, relay state, turn-on stamps and the seconds clock;
// depends on ospc_pkg.
module ospc_ctrl #(
  parameter int unsigned TimeWidth = ospc_pkg::TIME_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,   // item in the input register is consumed
  input  ospc_pkg::ospc_item_t item_i,
  input  ospc_pkg::ospc_cfg_t  cfg_i,
  output ospc_pkg::ospc_res_t  res_o
);
  import ospc_pkg::*;

  // Compare width wide enough for both elapsed time and hold value
  localparam int unsigned CmpW = (TimeWidth > HOLD_W) ? TimeWidth : HOLD_W;

  phase_e               phase_q, phase_d;
  logic                 relay_q, relay_d;
  logic                 sw_on_q, sw_on_d;
  logic                 key_on_q, key_on_d;
  logic                 pres_on_q, pres_on_d;
  logic [TimeWidth-1:0] key_stamp_q, key_stamp_d;
  logic [TimeWidth-1:0] pres_stamp_q, pres_stamp_d;
  logic [TimeWidth-1:0] secs_q, secs_d;

  logic [TimeWidth-1:0] key_elapsed, pres_elapsed;
  logic                 key_over, pres_over;
  logic                 off_ok;
  logic                 report, accepted;

  // Wrapped elapsed time since each turn-on, strictly over the hold time
  assign key_elapsed  = secs_q - key_stamp_q;
  assign pres_elapsed = secs_q - pres_stamp_q;
  assign key_over     = CmpW'(key_elapsed)  > CmpW'(cfg_i.key_hold);
  assign pres_over    = CmpW'(pres_elapsed) > CmpW'(cfg_i.pres_hold);

  // Remote off: key turn-on takes priority over presence turn-on
  always_comb begin
    if (key_on_q) begin
      off_ok = key_over;
    end else if (pres_on_q) begin
      off_ok = pres_over;
    end else begin
      off_ok = 1'b1;
    end
  end

  // Next state for one item
  always_comb begin
    phase_d      = phase_q;
    relay_d      = relay_q;
    sw_on_d      = sw_on_q;
    key_on_d     = key_on_q;
    pres_on_d    = pres_on_q;
    key_stamp_d  = key_stamp_q;
    pres_stamp_d = pres_stamp_q;
    secs_d       = secs_q;
    report       = 1'b0;
    accepted     = 1'b0;

    case (cmd_e'(item_i.command))
      CMD_KEY: begin
        // Debounce: low level means pressed
        unique case (phase_q)
          PH_IDLE:     phase_d = item_i.key_level ? PH_IDLE     : PH_FILTER;
          PH_FILTER:   phase_d = item_i.key_level ? PH_IDLE     : PH_PRESSED;
          PH_PRESSED:  phase_d = item_i.key_level ? PH_RELEASED : PH_PRESSED;
          PH_RELEASED: phase_d = item_i.key_level ? PH_IDLE     : PH_FILTER;
          default:     phase_d = PH_IDLE;
        endcase
        if (phase_d == PH_RELEASED) begin
          sw_on_d     = 1'b1;
          relay_d     = 1'b1;
          key_on_d    = 1'b1;
          key_stamp_d = secs_q;
          report      = 1'b1;
        end
      end
      CMD_PRESENCE: begin
        if (item_i.presence_level) begin
          relay_d      = 1'b1;
          sw_on_d      = 1'b1;
          pres_on_d    = 1'b1;
          pres_stamp_d = secs_q;
        end
      end
      CMD_REMOTE: begin
        case (remote_e'(item_i.remote_cmd))
          REM_ON: begin
            if (cfg_i.remote_en) begin
              relay_d      = 1'b1;
              sw_on_d      = 1'b1;
              pres_on_d    = 1'b1;
              pres_stamp_d = secs_q;
            end
          end
          REM_OFF: begin
            if (off_ok) begin
              if (key_on_q) key_on_d = 1'b0;
              relay_d      = 1'b0;
              sw_on_d      = 1'b0;
              pres_on_d    = 1'b0;
              pres_stamp_d = secs_q;
              accepted     = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: begin
        // One second tick, wraps at the clock width
        secs_d = secs_q + TimeWidth'(1);
      end
    endcase
  end

  // State registers, updated once per consumed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      relay_q      <= 1'b0;
      sw_on_q      <= 1'b1;
      key_on_q     <= 1'b0;
      pres_on_q    <= 1'b0;
      key_stamp_q  <= '0;
      pres_stamp_q <= '0;
      secs_q       <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      relay_q      <= relay_d;
      sw_on_q      <= sw_on_d;
      key_on_q     <= key_on_d;
      pres_on_q    <= pres_on_d;
      key_stamp_q  <= key_stamp_d;
      pres_stamp_q <= pres_stamp_d;
      secs_q       <= secs_d;
    end
  end

  // Result reflects the state after the update
  assign res_o.power_drive     = relay_d;
  assign res_o.switch_is_on    = sw_on_d;
  assign res_o.key_phase_out   = phase_d;
  assign res_o.presence_report = report;
  assign res_o.off_accepted    = accepted;

endmodule

// ----- sv/occupancy_power_switch_control_top.sv -----
// Occupancy power switch control: relay control from key, presence detector
// and remote commands, paced by one-second tick items.
//
// Channels: in_i carries one item (command, key level, presence level, remote
// request); out_o returns exactly one result item per input item, in order.
// Both use valid/ready; an item moves on a clock edge with both high.
// Configuration: cfg_we_i/cfg_idx_i/cfg_wdata_i write the key hold time,
// the presence hold time and the remote-on enable; write only when idle.
//
// Order: an accepted item is held in the input register, and its result is
// then written to the result register and presented on out_o until taken.
// Throughput: one item per cycle while out_o.ready stays high; the whole
// update is one compare-and-subtract pass between the two registers.
// Stalls: when out_o.ready is low the result register holds; the input
// register still takes one more item, after which in_i.ready drops.
// Reset: rst_ni clears both registers' valid flags, the debounce phase, the
// relay, stamps and seconds clock; switch flag resets to on, holds to 60 s.
// Depends on ospc_pkg, ospc_in_if, ospc_out_if, ospc_cfg_regs and ospc_ctrl.
module occupancy_power_switch_control_top #(
  parameter int unsigned TimeWidth = ospc_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ospc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ospc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ospc_in_if.sink                         in_i,
  ospc_out_if.source                      out_o
);
  import ospc_pkg::*;

  ospc_cfg_t  cfg;
  ospc_item_t item_q, item_in;
  logic       item_vld_q, item_vld_d;
  ospc_res_t  res_comb, res_q;
  logic       res_vld_q, res_vld_d;
  logic       res_free, step, in_fire;

  // Handshake: result register free when empty or being taken
  assign res_free   = !res_vld_q || out_o.ready;
  assign step       = item_vld_q && res_free;
  assign in_i.ready = !item_vld_q || res_free;
  assign in_fire    = in_i.valid && in_i.ready;

  assign item_in.command        = in_i.command;
  assign item_in.key_level      = in_i.key_level;
  assign item_in.presence_level = in_i.presence_level;
  assign item_in.remote_cmd     = in_i.remote_cmd;

  assign item_vld_d = in_fire || (item_vld_q && !step);
  assign res_vld_d  = step || (res_vld_q && !out_o.ready);

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= item_in;
    if (step)    res_q  <= res_comb;
  end

  ospc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ospc_ctrl #(
    .TimeWidth (TimeWidth)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_comb)
  );

  assign out_o.valid           = res_vld_q;
  assign out_o.power_drive     = res_q.power_drive;
  assign out_o.switch_is_on    = res_q.switch_is_on;
  assign out_o.key_phase_out   = res_q.key_phase_out;
  assign out_o.presence_report = res_q.presence_report;
  assign out_o.off_accepted    = res_q.off_accepted;

endmodule

// ----- tb/ospc_switch_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the occupancy power switch control block: watches both
// channels and the configuration port, predicts every result and compares it.
// Depends on ospc_pkg, ospc_in_if and ospc_out_if.
module ospc_switch_checker #(
  parameter int unsigned TimeWidth = ospc_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ospc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ospc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ospc_in_if                              in_i,
  ospc_out_if                             res_i,
  output int unsigned                     outstanding_o,
  output int unsigned                     mismatches_o
);
  import ospc_pkg::*;

  // Predicted switch state
  phase_e               key_ph;
  logic                 relay;
  logic                 sw_on;
  logic                 key_armed;
  logic                 pres_armed;
  logic [TimeWidth-1:0] key_stamp;
  logic [TimeWidth-1:0] pres_stamp;
  logic [TimeWidth-1:0] secs;

  // Register copies
  logic [HOLD_W-1:0] key_hold;
  logic [HOLD_W-1:0] pres_hold;
  logic              remote_en;

  // Results still owed by the block, oldest first
  ospc_res_t awaited_q[$];

  // Presence turn-on, shared by the detector and an enabled remote on
  function automatic void occupy();
    relay      = 1'b1;
    sw_on      = 1'b1;
    pres_armed = 1'b1;
    pres_stamp = secs;
  endfunction

  // Strictly more than the hold time since the stamp, on the wrapped clock
  function automatic logic held_past(logic [TimeWidth-1:0] stamp, logic [HOLD_W-1:0] hold);
    logic [TimeWidth-1:0] gap;
    gap = secs - stamp;
    return 64'(gap) > 64'(hold);
  endfunction

  // Applies one item to the predicted state and returns its result
  function automatic ospc_res_t advance_switch(ospc_item_t item);
    ospc_res_t res;
    logic      ok;
    res = '0;
    ok  = 1'b0;
    case (item.command)
      CMD_KEY: begin
        case (key_ph)
          PH_IDLE:    key_ph = item.key_level ? PH_IDLE : PH_FILTER;
          PH_FILTER:  key_ph = item.key_level ? PH_IDLE : PH_PRESSED;
          PH_PRESSED: key_ph = item.key_level ? PH_RELEASED : PH_PRESSED;
          default:    key_ph = item.key_level ? PH_IDLE : PH_FILTER;
        endcase
        if (key_ph == PH_RELEASED) begin
          relay               = 1'b1;
          sw_on               = 1'b1;
          key_armed           = 1'b1;
          key_stamp           = secs;
          res.presence_report = 1'b1;
        end
      end
      CMD_PRESENCE: begin
        if (item.presence_level) occupy();
      end
      CMD_REMOTE: begin
        if (item.remote_cmd == REM_ON) begin
          if (remote_en) occupy();
        end else if (item.remote_cmd == REM_OFF) begin
          // key turn-on takes priority; presence is not looked at then
          if (key_armed) begin
            ok = held_past(key_stamp, key_hold);
            if (ok) key_armed = 1'b0;
          end else if (pres_armed) begin
            ok = held_past(pres_stamp, pres_hold);
          end else begin
            ok = 1'b1;
          end
          if (ok) begin
            relay            = 1'b0;
            sw_on            = 1'b0;
            pres_armed       = 1'b0;
            pres_stamp       = secs;
            res.off_accepted = 1'b1;
          end
        end
      end
      default: secs = secs + 1'b1;
    endcase
    res.power_drive   = relay;
    res.switch_is_on  = sw_on;
    res.key_phase_out = key_ph;
    return res;
  endfunction

  // Predict on accepted items, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    ospc_item_t item;
    ospc_res_t  seen;
    ospc_res_t  want;
    if (!rst_ni) begin
      key_ph        = PH_IDLE;
      relay         = 1'b0;
      sw_on         = 1'b1;
      key_armed     = 1'b0;
      pres_armed    = 1'b0;
      key_stamp     = '0;
      pres_stamp    = '0;
      secs          = '0;
      key_hold      = KEY_HOLD_RST;
      pres_hold     = PRES_HOLD_RST;
      remote_en     = 1'b0;
      awaited_q.delete();
      outstanding_o = 0;
      mismatches_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY_HOLD:  key_hold  = cfg_wdata_i[HOLD_W-1:0];
          REG_PRES_HOLD: pres_hold = cfg_wdata_i[HOLD_W-1:0];
          REG_REMOTE_EN: remote_en = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        item = {in_i.command, in_i.key_level, in_i.presence_level, in_i.remote_cmd};
        awaited_q.push_back(advance_switch(item));
      end
      if (res_i.valid && res_i.ready) begin
        seen = {res_i.power_drive, res_i.switch_is_on, res_i.key_phase_out,
                res_i.presence_report, res_i.off_accepted};
        if (awaited_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: result item with none expected: drive=%0b on=%0b phase=%0d",
                     $time, seen.power_drive, seen.switch_is_on, seen.key_phase_out);
        end else begin
          want = awaited_q.pop_front();
          if (seen !== want) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display({"%0t: result mismatch: expected drive=%0b on=%0b phase=%0d ",
                        "report=%0b off=%0b, got drive=%0b on=%0b phase=%0d report=%0b off=%0b"},
                       $time, want.power_drive, want.switch_is_on, want.key_phase_out,
                       want.presence_report, want.off_accepted, seen.power_drive,
                       seen.switch_is_on, seen.key_phase_out, seen.presence_report,
                       seen.off_accepted);
          end
        end
      end
      outstanding_o = awaited_q.size();
    end
  end

endmodule

// ----- tb/occupancy_power_switch_control_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the occupancy power switch control block: directed and
// random items with bursty input, stalling output and several register settings.
// Depends on ospc_pkg, ospc_in_if, ospc_out_if, ospc_switch_checker and the block.
module occupancy_power_switch_control_top_tb;
  import ospc_pkg::*;

  // Narrow seconds clock so that it wraps within the run
  localparam int unsigned TIME_W          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 260;
  localparam int unsigned PHASES          = 5;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned HOLD_OFF_CYCLES = 40;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam logic [1:0]           REM_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = CFG_IDX_W'(3);

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           outstanding;
  int unsigned           mismatches;
  int unsigned           burst_left;
  int unsigned           items_sent;
  int unsigned           hold_off_asks;
  int unsigned           idle_run = 0;
  bit                    gaps_on;

  ospc_in_if  in_ch();
  ospc_out_if res_ch();

  occupancy_power_switch_control_top #(
    .TimeWidth(TIME_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (res_ch)
  );

  ospc_switch_checker #(
    .TimeWidth(TIME_W)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_i         (in_ch),
    .res_i        (res_ch),
    .outstanding_o(outstanding),
    .mismatches_o (mismatches)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_run <= 0;
      end else if (idle_run + 1 >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // Result side: stall patterns in random windows, long hold-off on request
  initial begin : result_sink
    int unsigned stall_mode;
    int unsigned window_left;
    int unsigned cyc;
    int unsigned holds_done;
    stall_mode   = 0;
    window_left  = 0;
    cyc          = 0;
    holds_done   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done != hold_off_asks) begin
        holds_done++;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (window_left == 0) begin
          stall_mode  = $urandom_range(0, 3);
          window_left = $urandom_range(8, 64);
        end
        window_left--;
        cyc++;
        case (stall_mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= 1'($urandom);
          2:       res_ch.ready <= ($urandom_range(0, 6) != 0);
          default: res_ch.ready <= (cyc % 4 != 0);
        endcase
      end
    end
  end

  // Input valid low for the given number of cycles
  task automatic pause(input int unsigned cycles);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Offer one item, in bursts with random gaps, and wait for its acceptance
  task automatic send(input logic [1:0] cmd, input logic key, input logic pres,
                      input logic [1:0] rem);
    int unsigned gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len    = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : 0;
      if (gap_len != 0) pause(gap_len);
    end
    burst_left--;
    @(negedge clk_i);
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.key_level      <= key;
    in_ch.presence_level <= pres;
    in_ch.remote_cmd     <= rem;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Stop offering until every result is in, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register write, single cycle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Mostly press/release sequences, ticks and remote requests; some noise
  task automatic random_items(input int unsigned count);
    int unsigned stop_at;
    int unsigned presses;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          presses = $urandom_range(1, 4);
          repeat (presses) send(CMD_KEY, 1'b0, 1'($urandom), 2'($urandom));
          send(CMD_KEY, 1'b1, 1'($urandom), 2'($urandom));
        end
        3: send(CMD_PRESENCE, 1'($urandom), 1'($urandom), 2'($urandom));
        4: send(CMD_REMOTE, 1'($urandom), 1'($urandom), REM_ON);
        5, 6: begin
          presses = $urandom_range(1, 24);
          repeat (presses) send(CMD_TICK, 1'($urandom), 1'($urandom), 2'($urandom));
        end
        7: send(CMD_REMOTE, 1'($urandom), 1'($urandom), REM_OFF);
        8: send(2'($urandom), 1'($urandom), 1'($urandom), 2'($urandom));
        default: send(CMD_KEY, 1'($urandom), 1'($urandom), 2'($urandom));
      endcase
    end
  endtask

  initial begin : stimulus
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_TICK;
    in_ch.key_level      = 1'b1;
    in_ch.presence_level = 1'b0;
    in_ch.remote_cmd     = REM_INVALID;
    burst_left           = 0;
    items_sent           = 0;
    hold_off_asks        = 0;
    gaps_on              = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under reset register values
    send(CMD_REMOTE,   1'b1, 1'b1, REM_OFF);      // nothing turned on: off at once
    send(CMD_REMOTE,   1'b0, 1'b0, REM_ON);       // remote on disabled
    send(CMD_REMOTE,   1'b1, 1'b0, REM_INVALID);
    send(CMD_REMOTE,   1'b0, 1'b1, REM_RESERVED);
    send(CMD_PRESENCE, 1'b1, 1'b0, REM_OFF);      // nobody present: no change
    send(CMD_PRESENCE, 1'b0, 1'b1, REM_RESERVED); // presence turn-on
    send(CMD_REMOTE,   1'b0, 1'b0, REM_OFF);      // presence hold not passed
    send(CMD_KEY,      1'b1, 1'b0, REM_INVALID);  // idle stays idle
    send(CMD_KEY,      1'b0, 1'b1, REM_ON);
    send(CMD_KEY,      1'b1, 1'b0, REM_OFF);      // bounce back to idle
    send(CMD_KEY,      1'b0, 1'b0, REM_INVALID);
    send(CMD_KEY,      1'b0, 1'b1, REM_RESERVED);
    send(CMD_KEY,      1'b0, 1'b0, REM_ON);       // held pressed
    send(CMD_KEY,      1'b1, 1'b1, REM_OFF);      // released: key turn-on
    send(CMD_KEY,      1'b0, 1'b0, REM_INVALID);  // released back to filtering
    send(CMD_KEY,      1'b0, 1'b1, REM_INVALID);
    send(CMD_KEY,      1'b1, 1'b0, REM_RESERVED);
    send(CMD_KEY,      1'b1, 1'b1, REM_ON);       // released to idle
    send(CMD_TICK,     1'b1, 1'b1, REM_RESERVED);
    send(CMD_TICK,     1'b0, 1'b0, REM_INVALID);
    send(CMD_REMOTE,   1'b1, 1'b1, REM_OFF);      // key hold not passed
    send(CMD_PRESENCE, 1'b0, 1'b1, REM_RESERVED);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain();
        case (p)
          1: begin
            write_reg(REG_KEY_HOLD,  16'd0);
            write_reg(REG_PRES_HOLD, 16'd0);
            write_reg(REG_REMOTE_EN, {15'($urandom), 1'b1});
          end
          2: begin
            write_reg(REG_KEY_HOLD,  16'hFFFF);
            write_reg(REG_PRES_HOLD, 16'hFFFF);
            write_reg(REG_REMOTE_EN, {15'($urandom), 1'b0});
            write_reg(REG_UNUSED,    16'($urandom));
          end
          3: begin
            write_reg(REG_KEY_HOLD,  16'($urandom_range(1, 40)));
            write_reg(REG_PRES_HOLD, 16'($urandom_range(1, 40)));
            write_reg(REG_REMOTE_EN, {15'($urandom), 1'($urandom)});
          end
          default: begin
            // just under and at the largest elapsed time the clock can show
            write_reg(REG_KEY_HOLD,  16'd254);
            write_reg(REG_PRES_HOLD, 16'd255);
            write_reg(REG_REMOTE_EN, {15'($urandom), 1'b1});
          end
        endcase
      end
      gaps_on = (p != 1);
      // result side holds off while items keep coming, so the input backs up
      send(CMD_TICK, 1'($urandom), 1'($urandom), 2'($urandom));
      hold_off_asks++;
      if (p == 3) begin
        random_items(ITEMS_PER_PHASE / 2);
        drain();
        random_items(ITEMS_PER_PHASE / 2);
      end else begin
        random_items(ITEMS_PER_PHASE);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ospc_pkg.sv
sv/ospc_in_if.sv
sv/ospc_out_if.sv
sv/ospc_cfg_regs.sv
sv/ospc_ctrl.sv
sv/occupancy_power_switch_control_top.sv
tb/ospc_switch_checker.sv
tb/occupancy_power_switch_control_top_tb.sv
